// ===== hw/rtl/ddwsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ddwsc_pkg
// Shared types and constants of the differential drive wheel speed command.
// ----------------------------------------------------------------------------
package ddwsc_pkg;

  localparam int W_GAIN  = 16;
  localparam int W_TRACK = 24;
  localparam int W_LIM   = 15;
  localparam int W_VAL   = 32;
  localparam int W_VEL   = 40;
  localparam int W_SPEED = 49;
  localparam int W_MAG   = 48;
  localparam int W_NUM   = W_MAG + W_LIM;
  localparam int W_WORD  = 16;
  localparam int W_CFG   = 24;

  localparam logic [2:0] REG_GAIN_DIST    = 3'd0;
  localparam logic [2:0] REG_GAIN_ANGLE   = 3'd1;
  localparam logic [2:0] REG_HALF_TRACK   = 3'd2;
  localparam logic [2:0] REG_SPEED_LIMIT  = 3'd3;
  localparam logic [2:0] REG_DRIVE_OPCODE = 3'd4;

  localparam logic [2:0] SLOT_OPCODE   = 3'd0;
  localparam logic [2:0] SLOT_RIGHT_HI = 3'd1;
  localparam logic [2:0] SLOT_RIGHT_LO = 3'd2;
  localparam logic [2:0] SLOT_LEFT_HI  = 3'd3;
  localparam logic [2:0] SLOT_LEFT_LO  = 3'd4;

  typedef struct packed {
    logic              clamp;
    logic              right_scaled;
    logic              other_neg;
    logic              big_neg;
    logic [W_WORD-1:0] right_trunc;
    logic [W_WORD-1:0] left_trunc;
  } side_t;

endpackage

// ===== hw/rtl/diff_drive_wheel_speed_command.sv =====
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_command
// Turns a motion request into a five-byte differential drive command.
// ----------------------------------------------------------------------------
// Each request yields five output bytes, one per cycle while the output is
// ready; the byte serializer takes the next request as the last byte of the
// current one is taken. A request passes through 23 register stages (three
// for gains and the turn term, three for the limit test and scaling products,
// sixteen for the quotient, one in the byte serializer). Stalls at the output
// hold the pipeline in place. Configuration is always ready.
module diff_drive_wheel_speed_command #(
  parameter int VALUE_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic signed [ddwsc_pkg::W_VAL-1:0] first_value,
  input  logic signed [ddwsc_pkg::W_VAL-1:0] second_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic                               last_byte,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [2:0]                         cfg_index,
  input  logic [ddwsc_pkg::W_CFG-1:0]        cfg_data
);

  logic signed [ddwsc_pkg::W_GAIN-1:0] gain_dist, gain_angle;
  logic [ddwsc_pkg::W_TRACK-1:0] half_track;
  logic [ddwsc_pkg::W_LIM-1:0] speed_limit;
  logic [7:0] drive_opcode;

  logic t_valid, t_ready;
  logic signed [ddwsc_pkg::W_SPEED-1:0] right_speed, left_speed;
  logic c_valid, c_ready;
  logic [ddwsc_pkg::W_NUM-1:0] num;
  logic [ddwsc_pkg::W_MAG-1:0] den;
  ddwsc_pkg::side_t c_side, d_side;
  logic d_valid, d_ready;
  logic [ddwsc_pkg::W_LIM-1:0] quotient;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_dist <= 16'sd256;
      gain_angle <= 16'sd256;
      half_track <= 24'd8519680;
      speed_limit <= 15'd500;
      drive_opcode <= 8'd145;
    end else if (cfg_valid) begin
      case (cfg_index)
        ddwsc_pkg::REG_GAIN_DIST:    gain_dist <= cfg_data[15:0];
        ddwsc_pkg::REG_GAIN_ANGLE:   gain_angle <= cfg_data[15:0];
        ddwsc_pkg::REG_HALF_TRACK:   half_track <= cfg_data;
        ddwsc_pkg::REG_SPEED_LIMIT:  speed_limit <= cfg_data[14:0];
        ddwsc_pkg::REG_DRIVE_OPCODE: drive_opcode <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ddwsc_turn u_turn (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .first_value  (first_value),
    .second_value (second_value),
    .gain_dist    (gain_dist),
    .gain_angle   (gain_angle),
    .half_track   (half_track),
    .out_valid    (t_valid),
    .out_ready    (t_ready),
    .right_speed  (right_speed),
    .left_speed   (left_speed)
  );

  ddwsc_clamp #(
    .VALUE_FRAC_BITS (VALUE_FRAC_BITS)
  ) u_clamp (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (t_valid),
    .in_ready    (t_ready),
    .right_speed (right_speed),
    .left_speed  (left_speed),
    .speed_limit (speed_limit),
    .out_valid   (c_valid),
    .out_ready   (c_ready),
    .num         (num),
    .den         (den),
    .side        (c_side)
  );

  ddwsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .num       (num),
    .den       (den),
    .side      (c_side),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .quotient  (quotient),
    .side_out  (d_side)
  );

  ddwsc_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (d_valid),
    .in_ready     (d_ready),
    .quotient     (quotient),
    .side         (d_side),
    .speed_limit  (speed_limit),
    .drive_opcode (drive_opcode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .last_byte    (last_byte)
  );

endmodule

// ===== hw/rtl/ddwsc_turn.sv =====
// ----------------------------------------------------------------------------
// ddwsc_turn
// Three stages: gains, split turn products, wheel sums.
// ----------------------------------------------------------------------------
module ddwsc_turn (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic signed [ddwsc_pkg::W_VAL-1:0]  first_value,
  input  logic signed [ddwsc_pkg::W_VAL-1:0]  second_value,
  input  logic signed [ddwsc_pkg::W_GAIN-1:0] gain_dist,
  input  logic signed [ddwsc_pkg::W_GAIN-1:0] gain_angle,
  input  logic [ddwsc_pkg::W_TRACK-1:0]       half_track,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ddwsc_pkg::W_SPEED-1:0] right_speed,
  output logic signed [ddwsc_pkg::W_SPEED-1:0] left_speed
);

  logic s1_valid, s2_valid, s3_valid;
  logic adv1, adv2, adv3;
  logic signed [47:0] pv, pw;
  logic signed [ddwsc_pkg::W_VEL-1:0] v_next, w_next;
  logic signed [ddwsc_pkg::W_VEL-1:0] v1, w1, v2;
  logic signed [44:0] ph_next, ph;
  logic [43:0] pl_next, pl;
  logic signed [63:0] prod;
  logic signed [47:0] turn;

  assign adv3 = !s3_valid || out_ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign in_ready = adv1;
  assign out_valid = s3_valid;

  always_comb begin
    pv = first_value * gain_dist;
    pw = second_value * gain_angle;
    if (op) begin
      v_next = {{8{first_value[31]}}, first_value};
      w_next = {{8{second_value[31]}}, second_value};
    end else begin
      v_next = pv[47:8];
      w_next = pw[47:8];
    end
  end

  always_comb begin
    ph_next = $signed(w1[39:20]) * $signed({1'b0, half_track});
    pl_next = w1[19:0] * half_track;
    prod = ({{19{ph[44]}}, ph} <<< 20) + $signed({20'b0, pl});
    turn = prod[63:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      v1 <= v_next;
      w1 <= w_next;
    end
    if (adv2 && s1_valid) begin
      v2 <= v1;
      ph <= ph_next;
      pl <= pl_next;
    end
    if (adv3 && s2_valid) begin
      right_speed <= {{9{v2[39]}}, v2} - {turn[47], turn};
      left_speed  <= {{9{v2[39]}}, v2} + {turn[47], turn};
    end
  end

endmodule

// ===== hw/rtl/ddwsc_clamp.sv =====
// ----------------------------------------------------------------------------
// ddwsc_clamp
// Three stages: limit test and truncation, split scale products, numerator.
// ----------------------------------------------------------------------------
module ddwsc_clamp #(
  parameter int VALUE_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [ddwsc_pkg::W_SPEED-1:0] right_speed,
  input  logic signed [ddwsc_pkg::W_SPEED-1:0] left_speed,
  input  logic [ddwsc_pkg::W_LIM-1:0]          speed_limit,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ddwsc_pkg::W_NUM-1:0]          num,
  output logic [ddwsc_pkg::W_MAG-1:0]          den,
  output ddwsc_pkg::side_t                     side
);

  logic s1_valid, s2_valid, s3_valid;
  logic adv1, adv2, adv3;
  logic [ddwsc_pkg::W_MAG-1:0] ar, al, lim_fx, ar_sh, al_sh;
  logic [ddwsc_pkg::W_SPEED-1:0] nr, nl;
  logic [ddwsc_pkg::W_WORD-1:0] tr, tl;
  ddwsc_pkg::side_t side_next, side1, side2;
  logic [ddwsc_pkg::W_MAG-1:0] other1, den1, den2;
  logic [38:0] phi, plo;

  assign adv3 = !s3_valid || out_ready;
  assign adv2 = !s2_valid || adv3;
  assign adv1 = !s1_valid || adv2;
  assign in_ready = adv1;
  assign out_valid = s3_valid;

  always_comb begin
    nr = -right_speed;
    nl = -left_speed;
    ar = right_speed[48] ? nr[47:0] : right_speed[47:0];
    al = left_speed[48] ? nl[47:0] : left_speed[47:0];
    lim_fx = ddwsc_pkg::W_MAG'(speed_limit) << VALUE_FRAC_BITS;
    ar_sh = ar >> VALUE_FRAC_BITS;
    al_sh = al >> VALUE_FRAC_BITS;
    tr = ar_sh[15:0];
    tl = al_sh[15:0];
    side_next.clamp = (ar > lim_fx) || (al > lim_fx);
    side_next.right_scaled = !(ar > al);
    side_next.other_neg = side_next.right_scaled ? right_speed[48] : left_speed[48];
    side_next.big_neg = side_next.right_scaled ? left_speed[48] : right_speed[48];
    side_next.right_trunc = right_speed[48] ? -tr : tr;
    side_next.left_trunc = left_speed[48] ? -tl : tl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (adv1) s1_valid <= in_valid;
      if (adv2) s2_valid <= s1_valid;
      if (adv3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      side1 <= side_next;
      other1 <= side_next.right_scaled ? ar : al;
      den1 <= side_next.right_scaled ? al : ar;
    end
    if (adv2 && s1_valid) begin
      side2 <= side1;
      den2 <= den1;
      phi <= other1[47:24] * speed_limit;
      plo <= other1[23:0] * speed_limit;
    end
    if (adv3 && s2_valid) begin
      side <= side2;
      den <= den2;
      num <= {phi, 24'b0} + {24'b0, plo};
    end
  end

endmodule

// ===== hw/rtl/ddwsc_div.sv =====
// ----------------------------------------------------------------------------
// ddwsc_div
// Pipelined restoring divider, one quotient bit per stage after the input stage.
// ----------------------------------------------------------------------------
module ddwsc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ddwsc_pkg::W_NUM-1:0] num,
  input  logic [ddwsc_pkg::W_MAG-1:0] den,
  input  ddwsc_pkg::side_t            side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ddwsc_pkg::W_LIM-1:0] quotient,
  output ddwsc_pkg::side_t            side_out
);

  localparam int N = ddwsc_pkg::W_LIM;

  logic [N:0] vld;
  logic [N+1:0] rdy;
  logic [ddwsc_pkg::W_NUM-1:0] rem [0:N-1];
  logic [ddwsc_pkg::W_MAG-1:0] dv [0:N-1];
  logic [N-1:0] quo [0:N];
  ddwsc_pkg::side_t sd [0:N];
  logic [ddwsc_pkg::W_NUM-1:0] shifted [1:N];
  logic [ddwsc_pkg::W_NUM-1:0] diff [1:N];
  logic hit [1:N];

  always_comb begin
    rdy[N+1] = out_ready;
    for (int j = N; j >= 0; j--) begin
      rdy[j] = !vld[j] || rdy[j+1];
    end
  end

  always_comb begin
    for (int j = 1; j <= N; j++) begin
      shifted[j] = {{N{1'b0}}, dv[j-1]} << (N - j);
      hit[j] = rem[j-1] >= shifted[j];
      diff[j] = rem[j-1] - shifted[j];
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = vld[N];
  assign quotient = quo[N];
  assign side_out = sd[N];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) vld[0] <= in_valid;
      for (int j = 1; j <= N; j++) begin
        if (rdy[j]) vld[j] <= vld[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      rem[0] <= num;
      dv[0] <= den;
      quo[0] <= '0;
      sd[0] <= side;
    end
    for (int j = 1; j < N; j++) begin
      if (rdy[j] && vld[j-1]) begin
        rem[j] <= hit[j] ? diff[j] : rem[j-1];
        dv[j] <= dv[j-1];
      end
    end
    for (int j = 1; j <= N; j++) begin
      if (rdy[j] && vld[j-1]) begin
        quo[j] <= quo[j-1] | (N'(hit[j]) << (N - j));
        sd[j] <= sd[j-1];
      end
    end
  end

endmodule

// ===== hw/rtl/ddwsc_serial.sv =====
// ----------------------------------------------------------------------------
// ddwsc_serial
// Resolves both wheel words and sends the five command bytes.
// ----------------------------------------------------------------------------
module ddwsc_serial (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [ddwsc_pkg::W_LIM-1:0] quotient,
  input  ddwsc_pkg::side_t            side,
  input  logic [ddwsc_pkg::W_LIM-1:0] speed_limit,
  input  logic [7:0]                  drive_opcode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        last_byte
);

  logic busy;
  logic [2:0] cnt;
  logic [ddwsc_pkg::W_WORD-1:0] right_word, left_word;
  logic [ddwsc_pkg::W_WORD-1:0] scaled, clamped, right_next, left_next;
  logic take;

  assign last_byte = (cnt == ddwsc_pkg::SLOT_LEFT_LO);
  assign out_valid = busy;
  assign in_ready = !busy || (out_ready && last_byte);
  assign take = in_valid && in_ready;

  always_comb begin
    scaled = side.other_neg ? -{1'b0, quotient} : {1'b0, quotient};
    clamped = side.big_neg ? -{1'b0, speed_limit} : {1'b0, speed_limit};
    if (side.clamp) begin
      right_next = side.right_scaled ? scaled : clamped;
      left_next = side.right_scaled ? clamped : scaled;
    end else begin
      right_next = side.right_trunc;
      left_next = side.left_trunc;
    end
  end

  always_comb begin
    case (cnt)
      ddwsc_pkg::SLOT_OPCODE:   out_byte = drive_opcode;
      ddwsc_pkg::SLOT_RIGHT_HI: out_byte = right_word[15:8];
      ddwsc_pkg::SLOT_RIGHT_LO: out_byte = right_word[7:0];
      ddwsc_pkg::SLOT_LEFT_HI:  out_byte = left_word[15:8];
      ddwsc_pkg::SLOT_LEFT_LO:  out_byte = left_word[7:0];
      default:                  out_byte = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= ddwsc_pkg::SLOT_OPCODE;
    end else if (take) begin
      busy <= 1'b1;
      cnt <= ddwsc_pkg::SLOT_OPCODE;
    end else if (busy && out_ready) begin
      if (last_byte) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      right_word <= right_next;
      left_word <= left_next;
    end
  end

endmodule

// ===== verif/tb_diff_drive_wheel_speed_command.sv =====
// ----------------------------------------------------------------------------
// tb_diff_drive_wheel_speed_command
// Self-checking testbench for the differential drive wheel speed command.
// A short table of directed requests runs first, then random requests across
// several register settings. Each request's five bytes are predicted and
// checked in order. The output side stalls at random and holds off once for
// a long stretch.
// ----------------------------------------------------------------------------
module tb_diff_drive_wheel_speed_command;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } cmd_byte_t;

  typedef struct {
    bit          op;
    logic [31:0] first;
    logic [31:0] second;
    bit          known;
    logic [15:0] right;
    logic [15:0] left;
  } drive_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = 1'b0;
  logic signed [ddwsc_pkg::W_VAL-1:0] first_value = '0;
  logic signed [ddwsc_pkg::W_VAL-1:0] second_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_byte;
  logic last_byte;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [ddwsc_pkg::W_CFG-1:0] cfg_data = '0;

  logic signed [15:0] gain_dist_q;
  logic signed [15:0] gain_angle_q;
  logic [23:0] half_track_q;
  logic [14:0] speed_limit_q;
  logic [7:0] opcode_q;

  cmd_byte_t pending_bytes[$];
  int errors = 0;
  int cycles = 0;
  int bytes_seen = 0;
  int hold_left = 0;
  bit hold_done = 0;

  diff_drive_wheel_speed_command dut (.*);

  always #10 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint mag64(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic [31:0] wheel_speeds(bit sel, logic [31:0] a, logic [31:0] b);
    longint v, w, turn, vr, vl, ar, al, lim, lim_fx, ir, il;
    v = longint'($signed(a));
    w = longint'($signed(b));
    if (!sel) begin
      v = (v * longint'(gain_dist_q)) >>> 8;
      w = (w * longint'(gain_angle_q)) >>> 8;
    end
    turn = (w * longint'({40'd0, half_track_q})) >>> 16;
    vr = v - turn;
    vl = v + turn;
    ar = mag64(vr);
    al = mag64(vl);
    lim = longint'({49'd0, speed_limit_q});
    lim_fx = lim <<< FRAC;
    if (ar > lim_fx || al > lim_fx) begin
      if (ar > al) begin
        il = (vl * lim) / ar;
        ir = vr > 0 ? lim : -lim;
      end else begin
        ir = (vr * lim) / al;
        il = vl > 0 ? lim : -lim;
      end
    end else begin
      ir = (ar >> FRAC) * (vr < 0 ? -1 : 1);
      il = (al >> FRAC) * (vl < 0 ? -1 : 1);
    end
    return {ir[15:0], il[15:0]};
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [23:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ddwsc_pkg::REG_GAIN_DIST: gain_dist_q = value[15:0];
      ddwsc_pkg::REG_GAIN_ANGLE: gain_angle_q = value[15:0];
      ddwsc_pkg::REG_HALF_TRACK: half_track_q = value;
      ddwsc_pkg::REG_SPEED_LIMIT: speed_limit_q = value[14:0];
      ddwsc_pkg::REG_DRIVE_OPCODE: opcode_q = value[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_request(drive_row_t row);
    logic [31:0] speeds;
    int gap;
    in_valid <= 1'b1;
    op <= row.op;
    first_value <= row.first;
    second_value <= row.second;
    do @(posedge clk); while (!in_ready);
    speeds = row.known ? {row.right, row.left} : wheel_speeds(row.op, row.first, row.second);
    pending_bytes.push_back('{opcode_q, 1'b0});
    pending_bytes.push_back('{speeds[31:24], 1'b0});
    pending_bytes.push_back('{speeds[23:16], 1'b0});
    pending_bytes.push_back('{speeds[15:8], 1'b0});
    pending_bytes.push_back('{speeds[7:0], 1'b1});
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return 32'($signed($urandom_range(0, 60000000)) - 30000000);
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
    endcase
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && bytes_seen >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (pick_gap() == 0);
    end
  end

  always @(posedge clk) begin
    cmd_byte_t want;
    if (!rst && out_valid && out_ready) begin
      bytes_seen <= bytes_seen + 1;
      if (pending_bytes.size() == 0) begin
        $error("unexpected byte %02h", out_byte);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte expected %02h actual %02h", want.data, out_byte);
          errors++;
        end
        if (last_byte !== want.last) begin
          $error("last_byte expected %0b actual %0b", want.last, last_byte);
          errors++;
        end
      end
    end
  end

  drive_row_t directed[] = '{
    '{1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0, 16'd0},
    '{1'b1, 32'h0064_0000, 32'h0000_0000, 1'b1, 16'd100, 16'd100},
    '{1'b1, 32'hFF9C_0000, 32'h0000_0000, 1'b1, -16'sd100, -16'sd100},
    '{1'b1, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 16'd500, 16'd500},
    '{1'b1, 32'h8000_0000, 32'h0000_0000, 1'b1, -16'sd500, -16'sd500},
    '{1'b0, 32'h01F4_0000, 32'h0000_0000, 1'b1, 16'd500, 16'd500},
    '{1'b0, 32'h01F4_0001, 32'h0000_0000, 1'b1, 16'd500, 16'd500},
    '{1'b1, 32'hFFFF_8000, 32'h0000_0000, 1'b1, 16'd0, 16'd0},
    '{1'b1, 32'h0000_0000, 32'h0000_8000, 1'b0, 16'd0, 16'd0},
    '{1'b1, 32'h0000_0000, 32'h0001_0000, 1'b0, 16'd0, 16'd0},
    '{1'b1, 32'h0000_0000, 32'hFFFF_0000, 1'b0, 16'd0, 16'd0},
    '{1'b1, 32'h0064_0000, 32'h0000_4000, 1'b0, 16'd0, 16'd0},
    '{1'b1, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 16'd0, 16'd0},
    '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd0, 16'd0},
    '{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'd0, 16'd0},
    '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 16'd0, 16'd0},
    '{1'b0, 32'h0123_4567, 32'hFEDC_BA98, 1'b0, 16'd0, 16'd0},
    '{1'b1, 32'h0190_0000, 32'h0000_0C00, 1'b0, 16'd0, 16'd0},
    '{1'b1, 32'hFE70_0000, 32'hFFFF_F400, 1'b0, 16'd0, 16'd0}
  };

  initial begin
    drive_row_t row;
    gain_dist_q = 16'sd256;
    gain_angle_q = 16'sd256;
    half_track_q = 24'd8519680;
    speed_limit_q = 15'd500;
    opcode_q = 8'd145;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i]);
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: begin
          write_reg(ddwsc_pkg::REG_GAIN_DIST, 24'h008000);
          write_reg(ddwsc_pkg::REG_GAIN_ANGLE, 24'h007FFF);
          write_reg(ddwsc_pkg::REG_HALF_TRACK, 24'hFFFFFF);
          write_reg(ddwsc_pkg::REG_SPEED_LIMIT, 24'd32767);
          write_reg(ddwsc_pkg::REG_DRIVE_OPCODE, 24'd255);
        end
        1: begin
          write_reg(ddwsc_pkg::REG_GAIN_DIST, 24'h007FFF);
          write_reg(ddwsc_pkg::REG_GAIN_ANGLE, 24'h008000);
          write_reg(ddwsc_pkg::REG_HALF_TRACK, 24'd0);
          write_reg(ddwsc_pkg::REG_SPEED_LIMIT, 24'd1);
          write_reg(ddwsc_pkg::REG_DRIVE_OPCODE, 24'd0);
        end
        2: begin
          write_reg(ddwsc_pkg::REG_GAIN_DIST, 24'd0);
          write_reg(ddwsc_pkg::REG_GAIN_ANGLE, 24'hFFFF00);
          write_reg(3'd5, 24'h123456);
          write_reg(3'd6, 24'hFFFFFF);
          write_reg(3'd7, 24'h000000);
        end
        default: begin
          write_reg(ddwsc_pkg::REG_GAIN_DIST, 24'($urandom()));
          write_reg(ddwsc_pkg::REG_GAIN_ANGLE, 24'($urandom()));
          write_reg(ddwsc_pkg::REG_HALF_TRACK, 24'($urandom()));
          write_reg(ddwsc_pkg::REG_SPEED_LIMIT, 24'($urandom_range(1, 32767)));
          write_reg(ddwsc_pkg::REG_DRIVE_OPCODE, 24'($urandom()));
        end
      endcase
      for (int n = 0; n < 52; n++) begin
        row.op = 1'($urandom_range(0, 1));
        row.first = rand_value();
        row.second = rand_value();
        row.known = 1'b0;
        row.right = '0;
        row.left = '0;
        send_request(row);
      end
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/ddwsc_pkg.sv
hw/rtl/ddwsc_turn.sv
hw/rtl/ddwsc_clamp.sv
hw/rtl/ddwsc_div.sv
hw/rtl/ddwsc_serial.sv
hw/rtl/diff_drive_wheel_speed_command.sv
verif/tb_diff_drive_wheel_speed_command.sv
